// ===== sv/nec_tx_pkg.sv =====
// shared types and constants for the nec infrared frame transmitter
`default_nettype none

package nec_tx_pkg;

  localparam int FRAME_BITS_DEFAULT = 32;
  localparam int WORD_BITS          = 32;
  localparam int CFG_INDEX_W        = 3;
  localparam int CFG_DATA_W         = 14;
  localparam int HALF_W             = 8;
  localparam int CYCLES_W           = 10;
  localparam int SPACE_W            = 14;

  localparam logic [HALF_W-1:0]   RST_CARRIER_HALF = 8'd13;
  localparam logic [CYCLES_W-1:0] RST_HDR_BURST    = 10'd345;
  localparam logic [SPACE_W-1:0]  RST_HDR_SPACE    = 14'd4500;
  localparam logic [CYCLES_W-1:0] RST_BIT_BURST    = 10'd24;
  localparam logic [SPACE_W-1:0]  RST_ZERO_SPACE   = 14'd535;
  localparam logic [SPACE_W-1:0]  RST_ONE_SPACE    = 14'd1630;
  localparam logic [CYCLES_W-1:0] RST_STOP_BURST   = 10'd22;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CARRIER_HALF = 3'd0,
    REG_HDR_BURST    = 3'd1,
    REG_HDR_SPACE    = 3'd2,
    REG_BIT_BURST    = 3'd3,
    REG_ZERO_SPACE   = 3'd4,
    REG_ONE_SPACE    = 3'd5,
    REG_STOP_BURST   = 3'd6
  } cfg_index_t;

  typedef enum logic [5:0] {
    PH_IDLE       = 6'b000001,
    PH_HDR_BURST  = 6'b000010,
    PH_HDR_SPACE  = 6'b000100,
    PH_BIT_BURST  = 6'b001000,
    PH_BIT_SPACE  = 6'b010000,
    PH_STOP_BURST = 6'b100000
  } phase_t;

  // effective register values, a zero write already mapped to one
  typedef struct packed {
    logic [HALF_W-1:0]   carrier_half;
    logic [CYCLES_W-1:0] hdr_burst;
    logic [SPACE_W-1:0]  hdr_space;
    logic [CYCLES_W-1:0] bit_burst;
    logic [SPACE_W-1:0]  zero_space;
    logic [SPACE_W-1:0]  one_space;
    logic [CYCLES_W-1:0] stop_burst;
  } cfg_t;

  typedef struct packed {
    logic req_type;
    logic [7:0] address_first;
    logic [7:0] address_second;
    logic [7:0] command;
  } req_t;

  typedef struct packed {
    logic ir_level;
    logic busy_res;
    logic rejected;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/nec_tx_req_if.sv =====
// request channel: tick or send request with frame bytes
`default_nettype none

interface nec_tx_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] address_first;
  logic [7:0] address_second;
  logic [7:0] command;

  modport source (output valid, req_type, address_first, address_second, command,
                  input ready);
  modport sink   (input valid, req_type, address_first, address_second, command,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/nec_tx_res_if.sv =====
// result channel: pin level and status after each request
`default_nettype none

interface nec_tx_res_if;
  logic valid;
  logic ready;
  logic ir_level;
  logic busy_res;
  logic rejected;

  modport source (output valid, ir_level, busy_res, rejected, input ready);
  modport sink   (input valid, ir_level, busy_res, rejected, output ready);
endinterface

`default_nettype wire

// ===== sv/nec_tx_cfg_if.sv =====
// configuration write channel
`default_nettype none

interface nec_tx_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [13:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/nec_tx_cfg_regs.sv =====
// timing register file, stores zero writes as one
`default_nettype none

module nec_tx_cfg_regs
  import nec_tx_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  nec_tx_cfg_if.sink cfg,
  output cfg_t       regs
);

  logic [CFG_DATA_W-1:0] data_nz;

  assign cfg.ready = 1'b1;
  // zero taken as one, for the full-width space registers
  assign data_nz = (cfg.data == '0) ? CFG_DATA_W'(1) : cfg.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.carrier_half <= RST_CARRIER_HALF;
      regs.hdr_burst    <= RST_HDR_BURST;
      regs.hdr_space    <= RST_HDR_SPACE;
      regs.bit_burst    <= RST_BIT_BURST;
      regs.zero_space   <= RST_ZERO_SPACE;
      regs.one_space    <= RST_ONE_SPACE;
      regs.stop_burst   <= RST_STOP_BURST;
    end else if (cfg.valid) begin
      case (cfg_index_t'(cfg.index))
        REG_CARRIER_HALF: begin
          regs.carrier_half <= (cfg.data[HALF_W-1:0] == '0) ? HALF_W'(1)
                                                             : cfg.data[HALF_W-1:0];
        end
        REG_HDR_BURST: begin
          regs.hdr_burst <= (cfg.data[CYCLES_W-1:0] == '0) ? CYCLES_W'(1)
                                                            : cfg.data[CYCLES_W-1:0];
        end
        REG_HDR_SPACE:  regs.hdr_space  <= data_nz;
        REG_BIT_BURST: begin
          regs.bit_burst <= (cfg.data[CYCLES_W-1:0] == '0) ? CYCLES_W'(1)
                                                            : cfg.data[CYCLES_W-1:0];
        end
        REG_ZERO_SPACE: regs.zero_space <= data_nz;
        REG_ONE_SPACE:  regs.one_space  <= data_nz;
        REG_STOP_BURST: begin
          regs.stop_burst <= (cfg.data[CYCLES_W-1:0] == '0) ? CYCLES_W'(1)
                                                             : cfg.data[CYCLES_W-1:0];
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/nec_tx_engine.sv =====
// frame sequencer: phase, shift register, counters and pin, one step per item
`default_nettype none

module nec_tx_engine
  import nec_tx_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step,
  input  req_t      item,
  input  cfg_t      regs,
  output res_t      res_next
);

  localparam int BITS_W = $clog2(FRAME_BITS + 1);

  phase_t              phase, phase_next;
  logic [WORD_BITS-1:0] frame_shift, frame_shift_next;
  logic [BITS_W-1:0]   bits_left, bits_left_next;
  logic [CYCLES_W-1:0] burst_left, burst_left_next;
  logic [SPACE_W-1:0]  space_left, space_left_next;
  logic [HALF_W-1:0]   half_count, half_count_next;
  logic                pin_level, pin_level_next;
  logic                rejected;

  logic [HALF_W-1:0]   half_inc;
  logic [CYCLES_W-1:0] burst_dec;
  logic [SPACE_W-1:0]  space_dec;
  logic [BITS_W-1:0]   bits_dec;

  assign half_inc  = half_count + HALF_W'(1);
  assign burst_dec = burst_left - CYCLES_W'(1);
  assign space_dec = space_left - SPACE_W'(1);
  assign bits_dec  = (bits_left != '0) ? bits_left - BITS_W'(1) : bits_left;

  always_comb begin
    phase_next       = phase;
    frame_shift_next = frame_shift;
    bits_left_next   = bits_left;
    burst_left_next  = burst_left;
    space_left_next  = space_left;
    half_count_next  = half_count;
    pin_level_next   = pin_level;
    rejected         = 1'b0;
    if (step) begin
      if (item.req_type) begin
        if (phase != PH_IDLE) begin
          rejected = 1'b1;
        end else begin
          frame_shift_next = {item.address_first, item.address_second,
                              item.command, ~item.command};
          bits_left_next   = BITS_W'(FRAME_BITS);
          phase_next       = PH_HDR_BURST;
          burst_left_next  = regs.hdr_burst;
          half_count_next  = '0;
          pin_level_next   = 1'b1;
        end
      end else begin
        case (phase)
          PH_HDR_BURST, PH_BIT_BURST, PH_STOP_BURST: begin
            // half period ends at the register or on counter wrap
            if (half_inc >= regs.carrier_half || half_inc == '0) begin
              half_count_next = '0;
              if (pin_level) begin
                pin_level_next = 1'b0;
              end else if (burst_dec != '0) begin
                burst_left_next = burst_dec;
                pin_level_next  = 1'b1;
              end else begin
                burst_left_next = '0;
                pin_level_next  = 1'b0;
                if (phase == PH_HDR_BURST) begin
                  phase_next      = PH_HDR_SPACE;
                  space_left_next = regs.hdr_space;
                end else if (phase == PH_BIT_BURST) begin
                  phase_next      = PH_BIT_SPACE;
                  space_left_next = frame_shift[WORD_BITS-1] ? regs.one_space
                                                             : regs.zero_space;
                end else begin
                  phase_next = PH_IDLE;
                end
              end
            end else begin
              half_count_next = half_inc;
            end
          end
          PH_HDR_SPACE, PH_BIT_SPACE: begin
            space_left_next = space_dec;
            if (space_dec == '0) begin
              half_count_next = '0;
              pin_level_next  = 1'b1;
              if (phase == PH_HDR_SPACE) begin
                phase_next      = PH_BIT_BURST;
                burst_left_next = regs.bit_burst;
              end else begin
                frame_shift_next = {frame_shift[WORD_BITS-2:0], 1'b0};
                bits_left_next   = bits_dec;
                if (bits_dec == '0) begin
                  phase_next      = PH_STOP_BURST;
                  burst_left_next = regs.stop_burst;
                end else begin
                  phase_next      = PH_BIT_BURST;
                  burst_left_next = regs.bit_burst;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign res_next.ir_level = pin_level_next;
  assign res_next.busy_res = (phase_next != PH_IDLE);
  assign res_next.rejected = rejected;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      frame_shift <= '0;
      bits_left   <= '0;
      burst_left  <= '0;
      space_left  <= '0;
      half_count  <= '0;
      pin_level   <= 1'b0;
    end else begin
      phase       <= phase_next;
      frame_shift <= frame_shift_next;
      bits_left   <= bits_left_next;
      burst_left  <= burst_left_next;
      space_left  <= space_left_next;
      half_count  <= half_count_next;
      pin_level   <= pin_level_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/nec_ir_frame_transmitter_core.sv =====
// top level of the nec infrared frame transmitter
`default_nettype none

// usage
//   req: one transfer per item. req_type 0 is a one microsecond tick, 1 asks
//   to send a frame of address_first, address_second, command, ~command,
//   msb first. a send while a frame is running is dropped and flagged.
//   res: one transfer per request with ir_level, busy_res and rejected as
//   they stand after that request.
//   cfg: timing register writes by index, always ready, meant for idle time.
// timing
//   a request lands in the input register on its transfer and its result
//   moves into the output register when the item advances, which raises
//   res.valid. one request per cycle while res is taken; sustained rate is
//   one item per clock unless res stalls, set by the single step of the
//   phase and counter logic between the regs.
// reset
//   rst (synchronous) empties both registers, puts the sequencer in idle
//   with the pin low and loads the default timing registers.
// stall
//   while res is not taken the output register holds, the input register
//   fills, and req.ready drops until the result moves on.

module nec_ir_frame_transmitter_core
  import nec_tx_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  nec_tx_req_if.sink   req,
  nec_tx_res_if.source res,
  nec_tx_cfg_if.sink   cfg
);

  cfg_t regs;
  req_t item;
  res_t res_next;
  res_t res_q;
  logic item_valid;
  logic res_valid;
  logic advance;

  nec_tx_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // input register moves on when the output register is free or drains
  assign advance   = item_valid && (!res_valid || res.ready);
  assign req.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      item.req_type       <= req.req_type;
      item.address_first  <= req.address_first;
      item.address_second <= req.address_second;
      item.command        <= req.command;
    end
  end

  nec_tx_engine #(
    .FRAME_BITS (FRAME_BITS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .item     (item),
    .regs     (regs),
    .res_next (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign res.valid    = res_valid;
  assign res.ir_level = res_q.ir_level;
  assign res.busy_res = res_q.busy_res;
  assign res.rejected = res_q.rejected;

  // a rejected send only happens while a frame is running
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.rejected |-> res.busy_res)
    else $error("rejected result without busy");

  // the emitter is never on outside a frame
  a_pin_busy: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.ir_level |-> res.busy_res)
    else $error("ir pin high while idle");

  // every item that leaves the input register shows up as a result
  a_advance_res: assert property (@(posedge clk) disable iff (rst)
    advance |=> res.valid)
    else $error("advanced item produced no result");

endmodule

`default_nettype wire
